/* src/bcw_pkg.sv */
// Shared constants and types for the crop warp block.
package bcw_pkg;

    localparam int MAX_WIDTH_DEF   = 512;
    localparam int MAX_HEIGHT_DEF  = 512;
    localparam int CROP_SIZE_DEF   = 192;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int POS_FRAC = 17;
    localparam int POS_W    = 48;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BOX_LEFT     = 3'd2;
    localparam logic [2:0] REG_BOX_TOP      = 3'd3;
    localparam logic [2:0] REG_BOX_RIGHT    = 3'd4;
    localparam logic [2:0] REG_BOX_BOTTOM   = 3'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CROP = 1'b1;

    // Geometry handed from the register block to the datapath.
    typedef struct packed {
        logic [9:0]         img_w;
        logic [9:0]         img_h;
        logic [31:0]        inv_scale;
        logic signed [12:0] cx_half;
        logic signed [12:0] cy_half;
    } t_geom;

endpackage

/* src/box_crop_bilinear_warp.sv */
// Top level of the crop warp block: address mapping pipeline and result strobe.
//
// Usage: pulse i_start with i_req_type and payload while o_busy is low
// (o_busy is always low; the block takes one item every cycle). A load
// item (req_type 0) writes one RGB pixel into the banked image store and
// produces no result. A crop item (req_type 1) maps the crop coordinate to
// a source point, reads the four neighbor taps together, one from each of
// four parity banks, and blends them; the result appears on o_red_out,
// o_green_out and o_blue_out with o_done high for one cycle, after the
// offset, product, source point, store read, weight and blend registers.
// Throughput is one item per clock, set by the single read port of each bank.
// The configuration port (i_cfg_valid, o_cfg_ready, index, data) is always
// ready; a box write refreshes the inverse scale through registered steps.
// Reset clears control state and registers to their reset values; the
// image store is undefined until loaded. The receiver cannot stall, so
// results leave the pipeline in order, one per crop item.
module box_crop_bilinear_warp
    import bcw_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int CROP_SIZE   = CROP_SIZE_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic [8:0]  i_img_x,
    input  logic [8:0]  i_img_y,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_crop_x,
    input  logic [7:0]  i_crop_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = 2 * WEIGHT_BITS + 1;
    localparam int FSH = POS_FRAC - WEIGHT_BITS;

    t_geom geom;

    bcw_cfg #(.CROP_SIZE(CROP_SIZE)) u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_geom(geom)
    );

    assign o_busy = 1'b0;

    logic n_acc;
    assign n_acc = i_start && !o_busy;

    // stage 1: offsets
    logic               r_v1;
    logic signed [9:0]  r_dx, r_dy;
    logic               n_ld;
    assign n_ld = n_acc && (i_req_type == REQ_LOAD)
        && (32'(i_img_x) < 32'(MAX_WIDTH)) && (32'(i_img_y) < 32'(MAX_HEIGHT));

    // delay loads to the read stage so earlier crops never see later loads
    logic [2:0]         r_ld;
    logic [2:0][XW-1:0] r_wx;
    logic [2:0][YW-1:0] r_wy;
    logic [2:0][23:0]   r_wd;

    // stage 2: products
    logic                    r_v2;
    logic signed [POS_W-1:0] r_px, r_py;
    // stage 3: source point
    logic                    r_v3;
    logic signed [POS_W-1:0] r_sx, r_sy;
    // stage 4: taps and weights
    logic                        r_v4;
    logic [WEIGHT_BITS:0]        r_fx, r_fy;
    logic [3:0]                  r_in4;
    logic                        r_v5;
    logic [3:0][WW-1:0]          r_w5;
    logic                        r_v6, r_v7;

    logic signed [POS_W-POS_FRAC-1:0] n_x0, n_y0;
    logic [WEIGHT_BITS:0] n_fx, n_fy;
    logic [3:0] n_in;
    logic [XW-1:0] n_rx;
    logic [YW-1:0] n_ry;
    logic signed [POS_W-POS_FRAC:0] n_x1, n_y1;

    always_comb begin
        n_x0 = r_sx[POS_W-1:POS_FRAC];
        n_y0 = r_sy[POS_W-1:POS_FRAC];
        n_fx = (WEIGHT_BITS+1)'(r_sx[POS_FRAC-1:FSH]);
        n_fy = (WEIGHT_BITS+1)'(r_sy[POS_FRAC-1:FSH]);
        n_x1 = (POS_W-POS_FRAC+1)'(n_x0) + 1;
        n_y1 = (POS_W-POS_FRAC+1)'(n_y0) + 1;
        n_in[0] = (n_x0 >= 0) && (n_y0 >= 0)
            && (n_x0 < $signed({1'b0, geom.img_w})) && (n_x0 < MAX_WIDTH)
            && (n_y0 < $signed({1'b0, geom.img_h})) && (n_y0 < MAX_HEIGHT);
        n_in[1] = (n_x1 >= 0) && (n_y0 >= 0)
            && (n_x1 < $signed({1'b0, geom.img_w})) && (n_x1 < MAX_WIDTH)
            && (n_y0 < $signed({1'b0, geom.img_h})) && (n_y0 < MAX_HEIGHT);
        n_in[2] = (n_x0 >= 0) && (n_y1 >= 0)
            && (n_x0 < $signed({1'b0, geom.img_w})) && (n_x0 < MAX_WIDTH)
            && (n_y1 < $signed({1'b0, geom.img_h})) && (n_y1 < MAX_HEIGHT);
        n_in[3] = (n_x1 >= 0) && (n_y1 >= 0)
            && (n_x1 < $signed({1'b0, geom.img_w})) && (n_x1 < MAX_WIDTH)
            && (n_y1 < $signed({1'b0, geom.img_h})) && (n_y1 < MAX_HEIGHT);
        n_rx = n_x0[XW-1:0];
        n_ry = n_y0[YW-1:0];
    end

    logic [3:0][23:0] rd_data;

    bcw_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
        .i_clk,
        .i_wr_en(r_ld[2]),
        .i_wr_x(r_wx[2]),
        .i_wr_y(r_wy[2]),
        .i_wr_data(r_wd[2]),
        .i_rd_x(n_rx),
        .i_rd_y(n_ry),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0;
            r_ld <= 3'd0;
        end else begin
            r_v1 <= n_acc && (i_req_type == REQ_CROP);
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6;
            r_ld <= {r_ld[1:0], n_ld};
        end
        r_wx <= {r_wx[1:0], XW'(i_img_x)};
        r_wy <= {r_wy[1:0], YW'(i_img_y)};
        r_wd <= {r_wd[1:0], i_red_in, i_green_in, i_blue_in};
        r_dx <= $signed({2'b0, i_crop_x} << 1) - 10'(CROP_SIZE);
        r_dy <= $signed({2'b0, i_crop_y} << 1) - 10'(CROP_SIZE);
        r_px <= POS_W'(r_dx) * $signed({16'd0, geom.inv_scale});
        r_py <= POS_W'(r_dy) * $signed({16'd0, geom.inv_scale});
        r_sx <= (POS_W'(geom.cx_half) <<< 16) + r_px;
        r_sy <= (POS_W'(geom.cy_half) <<< 16) + r_py;
        r_fx  <= n_fx;
        r_fy  <= n_fy;
        r_in4 <= n_in;
        // weights alongside the store read
        r_w5[0] <= WW'((WW'(1) << WEIGHT_BITS) - WW'(r_fx)) * WW'((WW'(1) << WEIGHT_BITS) - WW'(r_fy));
        r_w5[1] <= WW'(r_fx) * WW'((WW'(1) << WEIGHT_BITS) - WW'(r_fy));
        r_w5[2] <= WW'((WW'(1) << WEIGHT_BITS) - WW'(r_fx)) * WW'(r_fy);
        r_w5[3] <= WW'(r_fx) * WW'(r_fy);
    end

    // store data lands at stage 5 (read issued at stage 4 address)
    logic [3:0][23:0] r_tap;
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < 4; t++) begin
            r_tap[t] <= r_in4[t] ? rd_data[t] : 24'd0;
        end
    end

    logic [3:0][7:0] tr, tg, tb;
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            tr[t] = r_tap[t][23:16];
            tg[t] = r_tap[t][15:8];
            tb[t] = r_tap[t][7:0];
        end
    end

    // blend adds two stages: r_v6 -> products, r_v7 -> sum visible
    logic [15:0] red_v, green_v, blue_v;
    bcw_blend #(.WEIGHT_BITS(WEIGHT_BITS)) u_red   (.i_clk, .i_wgt(r_w5), .i_tap(tr), .o_value(red_v));
    bcw_blend #(.WEIGHT_BITS(WEIGHT_BITS)) u_green (.i_clk, .i_wgt(r_w5), .i_tap(tg), .o_value(green_v));
    bcw_blend #(.WEIGHT_BITS(WEIGHT_BITS)) u_blue  (.i_clk, .i_wgt(r_w5), .i_tap(tb), .o_value(blue_v));

    assign o_done      = r_v7;
    assign o_red_out   = red_v;
    assign o_green_out = green_v;
    assign o_blue_out  = blue_v;
endmodule

/* src/bcw_cfg.sv */
// Configuration registers and inverse scale computation.
module bcw_cfg
    import bcw_pkg::*;
#(
    parameter int CROP_SIZE = CROP_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_geom       o_geom
);
    localparam int DIV = 2 * CROP_SIZE;
    // floor reciprocal: numerator < 2^30, so the estimate is exact or one low
    localparam int RSH = 32;
    localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / DIV);

    logic [9:0]         r_img_w, r_img_h;
    logic signed [11:0] r_left, r_top, r_right, r_bottom;
    logic               r_upd;
    logic [1:0]         r_stage;
    logic [31:0]        r_num;
    logic [63:0]        r_prod;
    logic [31:0]        r_inv;
    logic signed [12:0] r_cx, r_cy;

    logic signed [13:0] n_w, n_h, n_side;
    logic [31:0]        n_num;
    logic [31:0]        n_q;
    logic [31:0]        n_rem;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_w    = 14'(r_right) - 14'(r_left) + 14'sd1;
        n_h    = 14'(r_bottom) - 14'(r_top) + 14'sd1;
        n_side = (n_w > n_h) ? n_w : n_h;
        if (n_side < 14'sd1) begin
            n_side = 14'sd1;
        end
        n_num = 32'(n_side) * 32'd196608 + 32'(CROP_SIZE);
        n_q   = 32'(r_prod >> RSH);
        n_rem = r_num - 32'(n_q * 32'(DIV));
        // correct a possible one-off quotient
        if (n_rem >= 32'(DIV)) begin
            n_q = n_q + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 10'd512;
            r_img_h  <= 10'd512;
            r_left   <= 12'sd0;
            r_top    <= 12'sd0;
            r_right  <= 12'sd191;
            r_bottom <= 12'sd191;
            r_upd    <= 1'b0;
            r_stage  <= 2'd0;
            r_inv    <= 32'd0;
            r_cx     <= 13'sd0;
            r_cy     <= 13'sd0;
        end else begin
            r_upd <= i_cfg_valid && ((i_cfg_index == REG_BOX_LEFT)
                || (i_cfg_index == REG_BOX_TOP) || (i_cfg_index == REG_BOX_RIGHT)
                || (i_cfg_index == REG_BOX_BOTTOM));
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[9:0];
                    REG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[9:0];
                    REG_BOX_LEFT:     r_left   <= i_cfg_data[11:0];
                    REG_BOX_TOP:      r_top    <= i_cfg_data[11:0];
                    REG_BOX_RIGHT:    r_right  <= i_cfg_data[11:0];
                    REG_BOX_BOTTOM:   r_bottom <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            // three-step scale update: numerator, reciprocal product, correction
            r_stage <= {r_stage[0], r_upd};
            if (r_upd) begin
                r_num <= n_num;
                r_cx  <= 13'(r_left) + 13'(r_right);
                r_cy  <= 13'(r_top) + 13'(r_bottom);
            end
            if (r_stage[0]) begin
                r_prod <= 64'(r_num) * 64'(RECIP);
            end
            if (r_stage[1]) begin
                r_inv <= n_q;
            end
        end
    end

    assign o_geom.img_w     = r_img_w;
    assign o_geom.img_h     = r_img_h;
    assign o_geom.inv_scale = r_inv;
    assign o_geom.cx_half   = r_cx;
    assign o_geom.cy_half   = r_cy;
endmodule

/* src/bcw_store.sv */
// Image store banked by x and y parity, four taps read per cycle.
module bcw_store
    import bcw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_wr_y,
    input  logic [23:0]                   i_wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_rd_y,
    output logic [3:0][23:0]              o_rd_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW - 2;
    localparam int DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

    logic [23:0] r_mem0 [DEPTH];
    logic [23:0] r_mem1 [DEPTH];
    logic [23:0] r_mem2 [DEPTH];
    logic [23:0] r_mem3 [DEPTH];

    logic [AW-1:0] n_wa;
    logic [1:0]    n_wb;
    // read: bank (px,py) gets x0 or x0+1 by parity
    logic [XW-1:0] n_xe, n_xo;
    logic [YW-1:0] n_ye, n_yo;
    logic [AW-1:0] n_a0, n_a1, n_a2, n_a3;

    always_comb begin
        n_wa = {i_wr_y[YW-1:1], i_wr_x[XW-1:1]};
        n_wb = {i_wr_y[0], i_wr_x[0]};
        n_xe = i_rd_x[0] ? i_rd_x + XW'(1) : i_rd_x;
        n_xo = i_rd_x[0] ? i_rd_x : i_rd_x + XW'(1);
        n_ye = i_rd_y[0] ? i_rd_y + YW'(1) : i_rd_y;
        n_yo = i_rd_y[0] ? i_rd_y : i_rd_y + YW'(1);
        n_a0 = {n_ye[YW-1:1], n_xe[XW-1:1]};
        n_a1 = {n_ye[YW-1:1], n_xo[XW-1:1]};
        n_a2 = {n_yo[YW-1:1], n_xe[XW-1:1]};
        n_a3 = {n_yo[YW-1:1], n_xo[XW-1:1]};
    end

    logic [23:0] r_b0, r_b1, r_b2, r_b3;
    logic [1:0]  r_par;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && n_wb == 2'd0) r_mem0[n_wa] <= i_wr_data;
        if (i_wr_en && n_wb == 2'd1) r_mem1[n_wa] <= i_wr_data;
        if (i_wr_en && n_wb == 2'd2) r_mem2[n_wa] <= i_wr_data;
        if (i_wr_en && n_wb == 2'd3) r_mem3[n_wa] <= i_wr_data;
        r_b0  <= r_mem0[n_a0];
        r_b1  <= r_mem1[n_a1];
        r_b2  <= r_mem2[n_a2];
        r_b3  <= r_mem3[n_a3];
        r_par <= {i_rd_y[0], i_rd_x[0]};
    end

    // route banks back to tap order: 0 (x0,y0) 1 (x0+1,y0) 2 (x0,y0+1) 3 (x0+1,y0+1)
    always_comb begin
        case (r_par)
            2'd0:    o_rd_data = {r_b3, r_b2, r_b1, r_b0};
            2'd1:    o_rd_data = {r_b2, r_b3, r_b0, r_b1};
            2'd2:    o_rd_data = {r_b1, r_b0, r_b3, r_b2};
            default: o_rd_data = {r_b0, r_b1, r_b2, r_b3};
        endcase
    end
endmodule

/* src/bcw_blend.sv */
// Bilinear blend of four taps, one color channel.
module bcw_blend
    import bcw_pkg::*;
#(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [3:0][2*WEIGHT_BITS:0] i_wgt,
    input  logic [3:0][7:0]          i_tap,
    output logic [15:0]              o_value
);
    localparam int WW    = 2 * WEIGHT_BITS + 1;
    localparam int PW    = WW + 8;
    localparam int AW    = PW + 2;
    localparam int SHIFT = 2 * WEIGHT_BITS - 8;

    logic [3:0][PW-1:0] r_prod;
    logic [AW-1:0]      r_sum;
    logic [AW-1:0]      n_round;

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < 4; t++) begin
            r_prod[t] <= PW'(i_wgt[t]) * PW'(i_tap[t]);
        end
        r_sum <= AW'(r_prod[0]) + AW'(r_prod[1]) + AW'(r_prod[2]) + AW'(r_prod[3]);
    end

    always_comb begin
        if (SHIFT > 0) begin
            n_round = (r_sum + (AW'(1) << (SHIFT > 0 ? SHIFT - 1 : 0))) >> SHIFT;
        end else begin
            n_round = r_sum;
        end
    end

    assign o_value = n_round[15:0];
endmodule
